>>> rtl/core/llpq_pkg.sv
package llpq_pkg;

    // Pool and list sizes
    localparam int NODES  = 256;
    localparam int LISTS  = 16;
    localparam int NODE_W = $clog2(NODES);
    localparam int LIST_W = $clog2(LISTS);
    localparam int OP_W   = 3;

    // Highest value the free count may hold
    localparam logic [NODE_W-1:0] COUNT_MAX = NODE_W'(NODES - 1);

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 3'd0,
        OP_RELEASE = 3'd1,
        OP_PUSH    = 3'd2,
        OP_APPEND  = 3'd3,
        OP_POP     = 3'd4,
        OP_DELINK  = 3'd5
    } t_op;

    // Result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // One access to the link store: a read or a write
    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [NODE_W-1:0] addr;
        logic [NODE_W-1:0] wdata;
    } t_link_req;

endpackage

>>> rtl/core/llpq_ram.sv
module llpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/llpq_link.sv
module llpq_link (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  llpq_pkg::t_link_req             i_req,
    output logic [llpq_pkg::NODE_W-1:0]     o_rdata
);

    logic [llpq_pkg::NODES-1:0]  r_valid;
    logic                        r_vq;
    logic [llpq_pkg::NODE_W-1:0] r_aq;
    logic [llpq_pkg::NODE_W-1:0] ram_q;
    logic [llpq_pkg::NODE_W-1:0] dflt;

    llpq_ram #(
        .WIDTH (llpq_pkg::NODE_W),
        .DEPTH (llpq_pkg::NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.wr),
        .i_waddr (i_req.addr),
        .i_wdata (i_req.wdata),
        .i_re    (i_req.rd),
        .i_raddr (i_req.addr),
        .o_rdata (ram_q)
    );

    // Written-entry flags; unwritten entries read as their reset link
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr) begin
            r_valid[i_req.addr] <= 1'b1;
        end
    end

    // Track the flag and address of the read in flight
    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_vq <= r_valid[i_req.addr];
            r_aq <= i_req.addr;
        end
    end

    // Reset link is the next node, wrapping at the top of the pool
    assign dflt    = (r_aq == llpq_pkg::COUNT_MAX) ? '0 : r_aq + 1'b1;
    assign o_rdata = r_vq ? ram_q : dflt;

endmodule

>>> rtl/core/linked_list_pool_queue_manager.sv
// Alloc reads the free head, then its link and writes (not on an empty pool); release reads,
// then writes twice; push/append on a non-empty list read, then write twice; pop reads once,
// or twice and then writes; delink reads, then writes; empty-list and unused-code words
// answer from idle. A new word is taken only once the last is done (single-port link RAM).
// Reset (i_rst_n low, synchronous) rebuilds the free list at once through written-entry flags.
// Results are shown for one cycle on o_strobe; the receiver cannot stall.
module linked_list_pool_queue_manager (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [llpq_pkg::OP_W-1:0]       i_op,
    input  logic [llpq_pkg::LIST_W-1:0]     i_list_id,
    input  logic [llpq_pkg::NODE_W-1:0]     i_node_id,
    input  logic [llpq_pkg::NODE_W-1:0]     i_prev_node_id,
    output logic                            o_strobe,
    output logic [llpq_pkg::NODE_W-1:0]     o_node_out,
    output logic                            o_status,
    output logic [llpq_pkg::NODE_W-1:0]     o_free_count_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC1,
        S_ALLOC2,
        S_REL1,
        S_REL2,
        S_PUSH1,
        S_PUSH2,
        S_POP1
    } t_state;

    // Extra states for the last step of pop and for delink
    typedef enum logic [1:0] {
        X_NONE,
        X_POP2,
        X_DEL1
    } t_ext;

    t_state r_state, n_state;
    t_ext   r_ext,   n_ext;

    logic [llpq_pkg::OP_W-1:0]   r_op, n_op;
    logic [llpq_pkg::LIST_W-1:0] r_lid, n_lid;
    logic [llpq_pkg::NODE_W-1:0] r_nid, n_nid;
    logic [llpq_pkg::NODE_W-1:0] r_pid, n_pid;
    logic [llpq_pkg::NODE_W-1:0] r_t, n_t;
    logic [llpq_pkg::NODE_W-1:0] r_h, n_h;
    logic [llpq_pkg::NODE_W-1:0] r_ft, n_ft;
    logic [llpq_pkg::NODE_W-1:0] r_cnt, n_cnt;
    logic [llpq_pkg::LISTS-1:0]  r_ne, n_ne;
    logic [llpq_pkg::NODE_W-1:0] r_lt [llpq_pkg::LISTS];
    logic                        r_strobe, n_strobe;
    logic [llpq_pkg::NODE_W-1:0] r_node_out, n_node_out;
    logic                        r_status, n_status;

    logic                        lt_we;
    logic [llpq_pkg::LIST_W-1:0] lt_idx;
    logic [llpq_pkg::NODE_W-1:0] lt_val;

    llpq_pkg::t_link_req         req;
    logic [llpq_pkg::NODE_W-1:0] link;

    llpq_link u_link (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rdata (link)
    );

    // Sequencer: each step issues at most one link access
    always_comb begin
        n_state    = r_state;
        n_ext      = r_ext;
        n_op       = r_op;
        n_lid      = r_lid;
        n_nid      = r_nid;
        n_pid      = r_pid;
        n_t        = r_t;
        n_h        = r_h;
        n_ft       = r_ft;
        n_cnt      = r_cnt;
        n_ne       = r_ne;
        n_strobe   = 1'b0;
        n_node_out = r_node_out;
        n_status   = r_status;
        lt_we      = 1'b0;
        lt_idx     = r_lid;
        lt_val     = r_nid;
        req        = '0;

        if (r_ext == X_POP2) begin
            // Unlink the head that follows the tail
            req.wr     = 1'b1;
            req.addr   = r_t;
            req.wdata  = link;
            n_strobe   = 1'b1;
            n_node_out = r_h;
            n_status   = llpq_pkg::STATUS_OK;
            n_ext      = X_NONE;
        end else if (r_ext == X_DEL1) begin
            // Predecessor skips the delinked node
            req.wr     = 1'b1;
            req.addr   = r_pid;
            req.wdata  = link;
            if (r_nid == r_pid) begin
                n_ne[r_lid] = 1'b0;
            end else if (r_t == r_nid) begin
                lt_we  = 1'b1;
                lt_val = r_pid;
            end
            n_strobe   = 1'b1;
            n_node_out = r_nid;
            n_status   = llpq_pkg::STATUS_OK;
            n_ext      = X_NONE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        n_op  = i_op;
                        n_lid = i_list_id;
                        n_nid = i_node_id;
                        n_pid = i_prev_node_id;
                        n_t   = r_lt[i_list_id];
                        case (i_op)
                            llpq_pkg::OP_ALLOC: begin
                                req.rd   = 1'b1;
                                req.addr = r_ft;
                                n_state  = S_ALLOC1;
                            end
                            llpq_pkg::OP_RELEASE: begin
                                req.rd   = 1'b1;
                                req.addr = r_ft;
                                n_state  = S_REL1;
                            end
                            llpq_pkg::OP_PUSH, llpq_pkg::OP_APPEND: begin
                                if (r_ne[i_list_id]) begin
                                    req.rd   = 1'b1;
                                    req.addr = r_lt[i_list_id];
                                    n_state  = S_PUSH1;
                                end else begin
                                    // First node links to itself
                                    req.wr            = 1'b1;
                                    req.addr          = i_node_id;
                                    req.wdata         = i_node_id;
                                    lt_we             = 1'b1;
                                    lt_idx            = i_list_id;
                                    lt_val            = i_node_id;
                                    n_ne[i_list_id]   = 1'b1;
                                    n_strobe          = 1'b1;
                                    n_node_out        = i_node_id;
                                    n_status          = llpq_pkg::STATUS_OK;
                                end
                            end
                            llpq_pkg::OP_POP: begin
                                if (r_ne[i_list_id]) begin
                                    req.rd   = 1'b1;
                                    req.addr = r_lt[i_list_id];
                                    n_state  = S_POP1;
                                end else begin
                                    n_strobe   = 1'b1;
                                    n_node_out = '0;
                                    n_status   = llpq_pkg::STATUS_EMPTY;
                                end
                            end
                            llpq_pkg::OP_DELINK: begin
                                if (r_ne[i_list_id]) begin
                                    req.rd   = 1'b1;
                                    req.addr = i_node_id;
                                    n_ext    = X_DEL1;
                                end else begin
                                    n_strobe   = 1'b1;
                                    n_node_out = '0;
                                    n_status   = llpq_pkg::STATUS_EMPTY;
                                end
                            end
                            default: begin
                                // Unused codes answer with nothing changed
                                n_strobe   = 1'b1;
                                n_node_out = '0;
                                n_status   = llpq_pkg::STATUS_OK;
                            end
                        endcase
                    end
                end
                S_ALLOC1: begin
                    // Head of free list; pool is empty when it is the tail
                    if (link == r_ft) begin
                        n_strobe   = 1'b1;
                        n_node_out = '0;
                        n_status   = llpq_pkg::STATUS_EMPTY;
                        n_state    = S_IDLE;
                    end else begin
                        n_h      = link;
                        req.rd   = 1'b1;
                        req.addr = link;
                        n_state  = S_ALLOC2;
                    end
                end
                S_ALLOC2: begin
                    req.wr     = 1'b1;
                    req.addr   = r_ft;
                    req.wdata  = link;
                    if (r_cnt != '0) begin
                        n_cnt = r_cnt - 1'b1;
                    end
                    n_strobe   = 1'b1;
                    n_node_out = r_h;
                    n_status   = llpq_pkg::STATUS_OK;
                    n_state    = S_IDLE;
                end
                S_REL1: begin
                    req.wr    = 1'b1;
                    req.addr  = r_nid;
                    req.wdata = link;
                    n_state   = S_REL2;
                end
                S_REL2: begin
                    // Released node becomes the free tail
                    req.wr     = 1'b1;
                    req.addr   = r_ft;
                    req.wdata  = r_nid;
                    n_ft       = r_nid;
                    if (r_cnt != llpq_pkg::COUNT_MAX) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    n_strobe   = 1'b1;
                    n_node_out = '0;
                    n_status   = llpq_pkg::STATUS_OK;
                    n_state    = S_IDLE;
                end
                S_PUSH1: begin
                    req.wr    = 1'b1;
                    req.addr  = r_nid;
                    req.wdata = link;
                    n_state   = S_PUSH2;
                end
                S_PUSH2: begin
                    req.wr     = 1'b1;
                    req.addr   = r_t;
                    req.wdata  = r_nid;
                    n_strobe   = 1'b1;
                    n_status   = llpq_pkg::STATUS_OK;
                    if (r_op == llpq_pkg::OP_APPEND) begin
                        lt_we      = 1'b1;
                        n_node_out = r_nid;
                    end else begin
                        n_node_out = r_t;
                    end
                    n_state    = S_IDLE;
                end
                S_POP1: begin
                    n_h = link;
                    if (link != r_t) begin
                        req.rd   = 1'b1;
                        req.addr = link;
                        n_ext    = X_POP2;
                    end else begin
                        n_ne[r_lid] = 1'b0;
                        n_strobe    = 1'b1;
                        n_node_out  = link;
                        n_status    = llpq_pkg::STATUS_OK;
                    end
                    n_state = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    // State, control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ext    <= X_NONE;
            r_ft     <= '0;
            r_cnt    <= llpq_pkg::COUNT_MAX;
            r_ne     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ext    <= n_ext;
            r_ft     <= n_ft;
            r_cnt    <= n_cnt;
            r_ne     <= n_ne;
            r_strobe <= n_strobe;
        end
        r_op       <= n_op;
        r_lid      <= n_lid;
        r_nid      <= n_nid;
        r_pid      <= n_pid;
        r_t        <= n_t;
        r_h        <= n_h;
        r_node_out <= n_node_out;
        r_status   <= n_status;
    end

    // List tails
    always_ff @(posedge i_clk) begin
        if (lt_we) begin
            r_lt[lt_idx] <= lt_val;
        end
    end

    assign busy             = (r_state != S_IDLE) || (r_ext != X_NONE);
    assign o_strobe         = r_strobe;
    assign o_node_out       = r_node_out;
    assign o_status         = r_status;
    assign o_free_count_out = r_cnt;

`ifndef SYNTHESIS
    // Every operation in progress ends with a result
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> busy || o_strobe)
        else $error("operation ended without a result");

    // A result only follows a taken word or work in progress
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy) || $past(start))
        else $error("result without a request");

    // No node is handed out with an empty status
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == llpq_pkg::STATUS_EMPTY) |-> o_node_out == '0)
        else $error("empty result carries a node");
`endif

endmodule
